### rtl/efp_pkg.sv
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types and constants of the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package efp_pkg;

  // field and datapath widths
  localparam int unsigned COORD_W = 12;  // pixel column and row
  localparam int unsigned ITER_W  = 12;  // iteration count
  localparam int unsigned COMP_W  = 32;  // one part of a complex value
  localparam int unsigned PROD_W  = 64;  // full product of two parts
  localparam int unsigned COL_W   = 8;   // one colour channel
  localparam int unsigned NUM_W   = 20;  // colour blend numerator
  localparam int unsigned CFG_W   = 32;  // configuration write data
  localparam int unsigned CFG_IDX_W = 3;

  // queue between the mapping front and the iteration back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_ORIGIN_X   = 3'd1,
    CFG_ORIGIN_Y   = 3'd2,
    CFG_PIXEL_STEP = 3'd3,
    CFG_JULIA_RE   = 3'd4,
    CFG_JULIA_IM   = 3'd5
  } efp_cfg_idx_e;

  // configuration register file contents
  typedef struct packed {
    logic              mandel_mode;
    logic [COMP_W-1:0] origin_x;
    logic [COMP_W-1:0] origin_y;
    logic [COMP_W-2:0] pixel_step;
    logic [COMP_W-1:0] julia_real;
    logic [COMP_W-1:0] julia_imag;
  } efp_cfg_t;

  // input pixel, column in the low bits
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } efp_pixel_t;

  // mapped start point handed from front to back end
  typedef struct packed {
    logic              mandel;
    logic [COMP_W-1:0] zr;
    logic [COMP_W-1:0] zi;
  } efp_job_t;

  // result item, escape flag in the low bit
  typedef struct packed {
    logic [COL_W-1:0]  blue;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  red;
    logic [ITER_W-1:0] iterations;
    logic              escaped;
  } efp_result_t;

  // four-entry colour palette, channels red, green, blue
  localparam logic [COL_W-1:0] EFP_PALETTE [4][3] = '{
    '{8'd0,   8'd20,  8'd100},
    '{8'd30,  8'd100, 8'd200},
    '{8'd230, 8'd255, 8'd255},
    '{8'd255, 8'd170, 8'd0}
  };

  // clamp a full-width signed value to the 32-bit signed range
  function automatic logic [COMP_W-1:0] efp_sat32(input logic [PROD_W-1:0] v);
    logic [COMP_W-1:0] res;
    if ((v[PROD_W-1:COMP_W-1] == '0) || (v[PROD_W-1:COMP_W-1] == '1)) begin
      res = v[COMP_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COMP_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### rtl/efp_fifo.sv
// ----------------------------------------------------------------------------
// efp_fifo
// Small register queue with a first-word-fall-through head.
// ----------------------------------------------------------------------------
module efp_fifo #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/efp_front.sv
// ----------------------------------------------------------------------------
// efp_front
// Accepts a pixel, maps it onto the complex plane with one shared
// multiplier and queues the start point with its Mandelbrot/Julia choice.
// ----------------------------------------------------------------------------
module efp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efp_pkg::efp_cfg_t  cfg_i,
  input  logic               pix_valid_i,
  output logic               pix_ready_o,
  input  efp_pkg::efp_pixel_t pix_i,
  input  logic               q_full_i,
  output logic               push_o,
  output efp_pkg::efp_job_t  job_o
);
  import efp_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_MAP_RE = 4'b0010,
    F_MAP_IM = 4'b0100,
    F_PUSH   = 4'b1000
  } efp_front_state_e;

  efp_front_state_e         state_q, state_d;
  efp_pixel_t               pix_q;
  logic [PROD_W-1:0]        prod_q;
  logic [COMP_W-1:0]        zr_q;
  logic [COORD_W-1:0]       coord;
  logic signed [COMP_W:0]   origin;
  logic signed [COMP_W:0]   delta;
  logic signed [COMP_W:0]   step_s;
  logic signed [2*COMP_W+1:0] prod_full;
  logic                     accept;

  assign pix_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  // shared mapping multiplier: column first, then row
  always_comb begin
    if (state_q == F_MAP_IM) begin
      coord  = pix_q.row;
      origin = $signed({cfg_i.origin_y[COMP_W-1], cfg_i.origin_y});
    end else begin
      coord  = pix_q.col;
      origin = $signed({cfg_i.origin_x[COMP_W-1], cfg_i.origin_x});
    end
    delta     = $signed({{(COMP_W+1-COORD_W){1'b0}}, coord}) - origin;
    step_s    = $signed({2'b00, cfg_i.pixel_step});
    prod_full = delta * step_s;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE:   if (accept) state_d = F_MAP_RE;
      F_MAP_RE: state_d = F_MAP_IM;
      F_MAP_IM: state_d = F_PUSH;
      F_PUSH: begin
        push_o  = 1'b1;
        state_d = F_IDLE;
      end
      default:  state_d = F_IDLE;
    endcase
  end

  assign job_o.mandel = cfg_i.mandel_mode;
  assign job_o.zr     = zr_q;
  assign job_o.zi     = efp_sat32(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coordinate and product registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_i;
    end
    if (state_q == F_MAP_RE || state_q == F_MAP_IM) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (state_q == F_MAP_IM) begin
      zr_q <= efp_sat32(prod_q);
    end
  end

endmodule

### rtl/efp_back.sv
// ----------------------------------------------------------------------------
// efp_back
// Iterates z = z*z + c for one queued point; if it escapes, blends the
// palette colour and divides it by the limit with a constant reciprocal
// multiply. Holds the result for the output.
// ----------------------------------------------------------------------------
module efp_back #(
  parameter int unsigned ITER_LIMIT = 200,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efp_pkg::efp_cfg_t    cfg_i,
  input  efp_pkg::efp_job_t    job_i,
  input  logic                 q_empty_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output efp_pkg::efp_result_t res_o
);
  import efp_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SQR  = 6'b000010,
    B_UPD  = 6'b000100,
    B_MIX  = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } efp_back_state_e;

  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);
  localparam logic [ITER_W-1:0] LIMIT     = ITER_W'(ITER_LIMIT);

  // reciprocal of the limit, exact for every blend numerator
  localparam int unsigned RECIP_W = NUM_W + 2;
  localparam int unsigned DIV_SH  = NUM_W + $clog2(ITER_LIMIT);
  localparam int unsigned QPROD_W = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(ITER_LIMIT) - 64'd1) / 64'(ITER_LIMIT));

  efp_back_state_e    state_q, state_d;
  logic [COMP_W-1:0]  zr_q, zi_q, cr_q, ci_q;
  logic [PROD_W-1:0]  sr_q, si_q, pz_q;
  logic [ITER_W-1:0]  iter_q;
  logic [1:0]         pal_q;
  logic [ITER_W-1:0]  frac_q;
  logic               esc_q;
  logic [NUM_W-1:0]   num_q [3];
  logic [COL_W-1:0]   quot_q [3];
  logic               out_valid_q, out_valid_d;
  efp_result_t        out_q;

  logic [COMP_W-1:0]        abs_r, abs_i;
  logic [PROD_W-1:0]        sum_sq;
  logic                     escape;
  logic signed [PROD_W-1:0] diff_sq, nr_full, ni_full;
  logic [1:0]               pal_nx;
  logic [ITER_W-1:0]        frac_nx;
  logic [1:0]               pal_up;
  logic [NUM_W-1:0]         wt_hi, wt_lo;
  logic [QPROD_W-1:0]       qprod [3];
  logic                     out_load;

  // magnitudes for the squares
  assign abs_r = zr_q[COMP_W-1] ? (~zr_q + COMP_W'(1)) : zr_q;
  assign abs_i = zi_q[COMP_W-1] ? (~zi_q + COMP_W'(1)) : zi_q;

  // escape test and next iterate
  always_comb begin
    sum_sq  = sr_q + si_q;
    escape  = (sum_sq >= ESC_LIMIT);
    diff_sq = $signed(sr_q) - $signed(si_q);
    nr_full = (diff_sq >>> FRAC_BITS) + $signed({{COMP_W{cr_q[COMP_W-1]}}, cr_q});
    ni_full = ($signed(pz_q) >>> (FRAC_BITS - 1))
              + $signed({{COMP_W{ci_q[COMP_W-1]}}, ci_q});
  end

  // palette position moves by four counts per iteration
  always_comb begin
    pal_nx  = pal_q;
    frac_nx = frac_q;
    for (int k = 0; k < 4; k++) begin
      if (frac_nx == LIMIT - ITER_W'(1)) begin
        frac_nx = '0;
        pal_nx  = pal_nx + 2'd1;
      end else begin
        frac_nx = frac_nx + ITER_W'(1);
      end
    end
  end

  // blend weights
  assign pal_up  = pal_q + 2'd1;
  assign wt_hi   = NUM_W'(LIMIT - frac_q);
  assign wt_lo   = NUM_W'(frac_q);

  // divide by the limit: multiply by the reciprocal, keep the high bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qprod[k] = QPROD_W'(num_q[k]) * QPROD_W'(RECIP);
    end
  end

  assign out_load    = (state_q == B_DONE) && (!out_valid_q || res_ready_i);
  assign pop_o       = (state_q == B_IDLE) && !q_empty_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!q_empty_i) state_d = B_SQR;
      B_SQR:  state_d = B_UPD;
      B_UPD: begin
        if (escape) begin
          state_d = B_MIX;
        end else if (iter_q + ITER_W'(1) == LIMIT) begin
          state_d = B_DONE;
        end else begin
          state_d = B_SQR;
        end
      end
      B_MIX:  state_d = B_DIV;
      B_DIV:  state_d = B_DONE;
      B_DONE: if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        zr_q   <= job_i.zr;
        zi_q   <= job_i.zi;
        cr_q   <= job_i.mandel ? job_i.zr : cfg_i.julia_real;
        ci_q   <= job_i.mandel ? job_i.zi : cfg_i.julia_imag;
        iter_q <= '0;
        pal_q  <= '0;
        frac_q <= '0;
      end
      B_SQR: begin
        sr_q <= PROD_W'(abs_r) * PROD_W'(abs_r);
        si_q <= PROD_W'(abs_i) * PROD_W'(abs_i);
        pz_q <= PROD_W'($signed({{COMP_W{zr_q[COMP_W-1]}}, zr_q})
                        * $signed({{COMP_W{zi_q[COMP_W-1]}}, zi_q}));
      end
      B_UPD: begin
        esc_q <= escape;
        if (!escape) begin
          zr_q   <= efp_sat32(nr_full);
          zi_q   <= efp_sat32(ni_full);
          iter_q <= iter_q + ITER_W'(1);
          pal_q  <= pal_nx;
          frac_q <= frac_nx;
          for (int k = 0; k < 3; k++) begin
            quot_q[k] <= '0;
          end
        end
      end
      B_MIX: begin
        for (int k = 0; k < 3; k++) begin
          num_q[k] <= NUM_W'(EFP_PALETTE[pal_q][k]) * wt_hi
                    + NUM_W'(EFP_PALETTE[pal_up][k]) * wt_lo;
        end
      end
      B_DIV: begin
        for (int k = 0; k < 3; k++) begin
          quot_q[k] <= COL_W'(qprod[k] >> DIV_SH);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.escaped    <= esc_q;
      out_q.iterations <= iter_q;
      out_q.red        <= quot_q[0];
      out_q.green      <= quot_q[1];
      out_q.blue       <= quot_q[2];
    end
  end

endmodule

### rtl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Mandelbrot / Julia escape-time iteration and palette colouring per pixel.
//
// Each pixel (column, row) is mapped to z0 = ((col - origin_x) * pixel_step,
// (row - origin_y) * pixel_step) in signed Q4.28, saturated to +/-8, and
// iterated as z = z*z + c until |z|^2 reaches 4 or ITER_LIMIT iterations are
// done; c is z0 in Mandelbrot mode and the julia_real/julia_imag pair
// otherwise. One result follows each pixel in order. The front end maps a
// pixel and drops it in a two-entry queue; each back-end iteration is a
// register stage of three 32x32 multipliers, then the escape compare and
// update. A pixel that escapes then gets a colour blend and a reciprocal
// multiply that divides by the limit; one that does not escape skips both.
// Pixels queue and results wait in an output register; a full queue stalls
// the pixel input and a held result stalls the back end. Registers are to
// be written only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
  parameter int unsigned ITER_LIMIT = 200,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [efp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [efp_pkg::CFG_W-1:0]     cfg_wdata_i,
  // pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // pixel_col, pixel_row
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata   // escaped, iterations, red,
                                                       // green, blue, zero pad
);
  import efp_pkg::*;

  efp_cfg_t    cfg_q, cfg_d;
  efp_job_t    push_job, head_job;
  logic        q_push, q_pop, q_full, q_empty;
  efp_result_t res;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (efp_cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       cfg_d.mandel_mode = cfg_wdata_i[0];
        CFG_ORIGIN_X:   cfg_d.origin_x    = cfg_wdata_i;
        CFG_ORIGIN_Y:   cfg_d.origin_y    = cfg_wdata_i;
        CFG_PIXEL_STEP: cfg_d.pixel_step  = cfg_wdata_i[COMP_W-2:0];
        CFG_JULIA_RE:   cfg_d.julia_real  = cfg_wdata_i;
        CFG_JULIA_IM:   cfg_d.julia_imag  = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mandel_mode <= 1'b1;
      cfg_q.origin_x    <= 32'd450;
      cfg_q.origin_y    <= 32'd300;
      cfg_q.pixel_step  <= 31'd1342177;
      cfg_q.julia_real  <= 32'd75161928;
      cfg_q.julia_imag  <= 32'd2147484;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // mapping front end
  efp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_i       (efp_pixel_t'(s_axis_tdata)),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (push_job)
  );

  // start point queue
  efp_fifo #(
    .WIDTH ($bits(efp_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_job),
    .pop_i   (q_pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // iteration and colouring back end
  efp_back #(
    .ITER_LIMIT (ITER_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res};

`ifndef SYNTHESIS
  // the front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("start point pushed into full queue");

  // the back end only pops a queue that holds a point
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("start point popped from empty queue");

  // an escaped pixel stopped before the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.escaped) |-> (res.iterations < ITER_W'(ITER_LIMIT)))
    else $error("escaped pixel reports iteration count at or beyond limit");

  // a pixel that stayed bounded ran to the limit and is black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.escaped) |->
      ((res.iterations == ITER_W'(ITER_LIMIT)) && (res.red == '0)
       && (res.green == '0) && (res.blue == '0)))
    else $error("bounded pixel not black or not at iteration limit");
`endif

endmodule
